>>> rtl/iiat_pkg.sv
// ----------------------------------------------------------------------------
// Integral-image adaptive threshold: shared definitions
// Sizes, field widths, register indexes and codes used by the threshold
// block, which also sizes its store RAMs from them.
// ----------------------------------------------------------------------------
package iiat_pkg;

	// Frame limits and fixed-point format.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 512;
	localparam int FRAC_BITS  = 16;

	// Position and address widths; the store address is {row, col}.
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

	// Data widths.
	localparam int PIX_W      = 8;
	localparam int INTEG_W    = 27;
	localparam int ROWSUM_W   = 18;
	localparam int BOX_W      = INTEG_W + 1;
	localparam int WCFG_W     = 11;
	localparam int HCFG_W     = 10;
	localparam int FACTOR_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Window half-size is width >> 4; a side spans at most twice that.
	localparam int HALF_W  = WCFG_W - 4;
	localparam int DIFF_W  = HALF_W + 1;
	localparam int COUNT_W = 2 * DIFF_W;
	localparam int LHS_W   = PIX_W + COUNT_W;
	localparam int PROD_W  = BOX_W + FACTOR_W;

	// Register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FACTOR = 2'd2;

	localparam logic [WCFG_W-1:0]   WIDTH_RESET  = 11'd640;
	localparam logic [HCFG_W-1:0]   HEIGHT_RESET = 10'd480;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd55706;

	// Item operations and output levels.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	localparam logic [PIX_W-1:0] BIN_DARK  = 8'd0;
	localparam logic [PIX_W-1:0] BIN_LIGHT = 8'd255;

	// Raster position wide enough to hold one step past the frame size.
	typedef struct packed {
		logic [WCFG_W-1:0] c;
		logic [HCFG_W-1:0] r;
	} pos_t;

endpackage

>>> rtl/iiat_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module iiat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/integral_image_adaptive_threshold.sv
// ----------------------------------------------------------------------------
// Integral-image adaptive threshold
// Loads a gray frame into a pixel store and an integral-image store, then
// emits one binarized pixel per emit beat by comparing it to its local mean.
// ----------------------------------------------------------------------------
// A load beat (op 0) writes the next pixel of the frame in raster order:
// the integral entry one row above is read from the integral RAM, then the
// new entry (above plus the running row sum) and the pixel are written. An
// emit beat (op 1) runs as follows: the four window corners go through the
// single read port of the integral RAM one per cycle (the pixel is read
// alongside the first), then the box sum and the pixel-times-count product
// are formed, then the box sum is scaled by threshold_factor, and the compare
// fills the output register once the result side is free. The block works on
// one beat at a time; while a result waits in the output register the next
// beat is still taken, and only the final step of a following emit waits for
// it to drain. The stores are not cleared after reset: a frame must be loaded
// completely before its pixels are emitted. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module integral_image_adaptive_threshold (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [iiat_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [iiat_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic                                     pix_valid,
	output logic                                     pix_ready,
	input  logic                                     op,
	input  logic [iiat_pkg::PIX_W-1:0]               pixel,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output logic [iiat_pkg::PIX_W-1:0]               bin_value,
	output logic [iiat_pkg::COL_W-1:0]               col,
	output logic [iiat_pkg::ROW_W-1:0]               row,
	output logic                                     last
);

	import iiat_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_EM_R0,
		ST_EM_R1,
		ST_EM_R2,
		ST_EM_R3,
		ST_EM_SUM,
		ST_EM_MUL,
		ST_EM_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [WCFG_W-1:0]   cfg_width_q;
	logic [HCFG_W-1:0]   cfg_height_q;
	logic [FACTOR_W-1:0] cfg_factor_q;

	// Raster counters and the running sum of the row being loaded.
	logic [COL_W-1:0]    load_col_q;
	logic [ROW_W-1:0]    load_row_q;
	logic [COL_W-1:0]    emit_col_q;
	logic [ROW_W-1:0]    emit_row_q;
	logic [ROWSUM_W-1:0] rowsum_q;

	// Context of the beat in flight.
	logic [COL_W-1:0]    ld_col_q;
	logic [ROW_W-1:0]    ld_row_q;
	logic [PIX_W-1:0]    ld_pix_q;
	logic [COL_W-1:0]    em_x_q, em_x1_q, em_x2_q;
	logic [ROW_W-1:0]    em_y_q, em_y1_q, em_y2_q;
	logic                em_last_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PIX_W-1:0]    em_pix_q;
	logic [INTEG_W-1:0]  i22_q, i21_q, i12_q;
	logic [BOX_W-1:0]    box_q;
	logic [LHS_W-1:0]    lhs_q;
	logic [BOX_W-1:0]    rhs_q;

	// Output register.
	logic                res_valid_q;
	logic [PIX_W-1:0]    bin_value_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                last_q;

	// Effective frame size and window geometry.
	logic [WCFG_W-1:0]   eff_w;
	logic [HCFG_W-1:0]   eff_h;
	logic [HALF_W-1:0]   half;
	pos_t                ld_pos, ld_nxt, em_pos, em_nxt;
	logic [COL_W-1:0]    ex, x1, x2;
	logic [ROW_W-1:0]    ey, y1, y2;
	logic [WCFG_W-1:0]   xs;
	logic [HCFG_W-1:0]   ys;
	logic                is_last;
	logic [DIFF_W-1:0]   dx, dy;
	logic [ROWSUM_W-1:0] rowsum_nxt;

	// Store ports.
	logic                integ_rd_en, integ_wr_en;
	logic [ADDR_W-1:0]   integ_rd_addr, integ_wr_addr;
	logic [INTEG_W-1:0]  integ_rd_data, integ_wr_data, above;
	logic                pix_rd_en;
	logic [PIX_W-1:0]    pix_rd_data;

	// Box sum of the four corners, with room for the sign.
	logic signed [BOX_W:0] box_full;
	logic [PROD_W-1:0]     prod;
	logic                  accept;

	// Wraps a counter that has run past the frame size to the next row or to
	// the top of the frame.
	function automatic pos_t norm_pos(input pos_t p, input logic [WCFG_W-1:0] w,
			input logic [HCFG_W-1:0] h);
		pos_t q;
		q = p;
		if (q.c >= w) begin
			q.c = '0;
			q.r = q.r + HCFG_W'(1);
		end
		if (q.r >= h) begin
			q.r = '0;
		end
		return q;
	endfunction

	always_comb begin
		if (cfg_width_q == '0) begin
			eff_w = WCFG_W'(1);
		end else if (cfg_width_q > WCFG_W'(MAX_WIDTH)) begin
			eff_w = WCFG_W'(MAX_WIDTH);
		end else begin
			eff_w = cfg_width_q;
		end
		if (cfg_height_q == '0) begin
			eff_h = HCFG_W'(1);
		end else if (cfg_height_q > HCFG_W'(MAX_HEIGHT)) begin
			eff_h = HCFG_W'(MAX_HEIGHT);
		end else begin
			eff_h = cfg_height_q;
		end
	end

	assign half = eff_w[WCFG_W-1:4];

	// Load and emit positions: wrap first, then step one pixel on.
	assign ld_pos = norm_pos(pos_t'{c: {1'b0, load_col_q}, r: {1'b0, load_row_q}},
		eff_w, eff_h);
	assign ld_nxt = norm_pos(pos_t'{c: ld_pos.c + WCFG_W'(1), r: ld_pos.r}, eff_w, eff_h);
	assign em_pos = norm_pos(pos_t'{c: {1'b0, emit_col_q}, r: {1'b0, emit_row_q}},
		eff_w, eff_h);
	assign em_nxt = norm_pos(pos_t'{c: em_pos.c + WCFG_W'(1), r: em_pos.r}, eff_w, eff_h);

	// The first pixel of a row restarts the running row sum.
	assign rowsum_nxt = (ld_pos.c == '0) ? ROWSUM_W'(pixel) : rowsum_q + ROWSUM_W'(pixel);

	// Window corners, clamped to the frame.
	always_comb begin
		ex = em_pos.c[COL_W-1:0];
		ey = em_pos.r[ROW_W-1:0];
		x1 = (ex >= COL_W'(half)) ? ex - COL_W'(half) : '0;
		xs = {1'b0, ex} + WCFG_W'(half);
		x2 = (xs > eff_w - WCFG_W'(1)) ? COL_W'(eff_w - WCFG_W'(1)) : xs[COL_W-1:0];
		y1 = ({1'b0, ey} >= HCFG_W'(half)) ? ey - ROW_W'(half) : '0;
		ys = {1'b0, ey} + HCFG_W'(half);
		y2 = (ys > eff_h - HCFG_W'(1)) ? ROW_W'(eff_h - HCFG_W'(1)) : ys[ROW_W-1:0];
		is_last = ({1'b0, ex} == eff_w - WCFG_W'(1)) && ({1'b0, ey} == eff_h - HCFG_W'(1));
	end

	assign dx = DIFF_W'(em_x2_q - em_x1_q);
	assign dy = DIFF_W'(em_y2_q - em_y1_q);

	assign pix_ready = (state_q == ST_IDLE);
	assign accept    = pix_valid && pix_ready;

	// The integral RAM read port serves the load's upper neighbor and the four
	// emit corners in turn.
	always_comb begin
		integ_rd_en   = 1'b0;
		integ_rd_addr = {em_y2_q, em_x2_q};
		case (state_q)
			ST_LD_RD: begin
				integ_rd_en   = (ld_row_q != '0);
				integ_rd_addr = {ld_row_q - ROW_W'(1), ld_col_q};
			end
			ST_EM_R0: begin
				integ_rd_en   = 1'b1;
				integ_rd_addr = {em_y2_q, em_x2_q};
			end
			ST_EM_R1: begin
				integ_rd_en   = 1'b1;
				integ_rd_addr = {em_y1_q, em_x2_q};
			end
			ST_EM_R2: begin
				integ_rd_en   = 1'b1;
				integ_rd_addr = {em_y2_q, em_x1_q};
			end
			ST_EM_R3: begin
				integ_rd_en   = 1'b1;
				integ_rd_addr = {em_y1_q, em_x1_q};
			end
			default: begin
				integ_rd_en   = 1'b0;
				integ_rd_addr = {em_y2_q, em_x2_q};
			end
		endcase
	end

	assign above         = (ld_row_q == '0) ? '0 : integ_rd_data;
	assign integ_wr_en   = (state_q == ST_LD_WR);
	assign integ_wr_addr = {ld_row_q, ld_col_q};
	assign integ_wr_data = above + INTEG_W'(rowsum_q);
	assign pix_rd_en     = (state_q == ST_EM_R0);

	assign box_full = $signed({2'b00, i22_q}) - $signed({2'b00, i21_q})
		- $signed({2'b00, i12_q}) + $signed({2'b00, integ_rd_data});
	assign prod = PROD_W'(box_q) * PROD_W'(cfg_factor_q);

	iiat_ram #(
		.WIDTH (INTEG_W),
		.DEPTH (DEPTH)
	) u_integ_ram (
		.clk     (clk),
		.wr_en   (integ_wr_en),
		.wr_addr (integ_wr_addr),
		.wr_data (integ_wr_data),
		.rd_en   (integ_rd_en),
		.rd_addr (integ_rd_addr),
		.rd_data (integ_rd_data)
	);

	iiat_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_pix_ram (
		.clk     (clk),
		.wr_en   (integ_wr_en),
		.wr_addr (integ_wr_addr),
		.wr_data (ld_pix_q),
		.rd_en   (pix_rd_en),
		.rd_addr ({em_y_q, em_x_q}),
		.rd_data (pix_rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= WIDTH_RESET;
			cfg_height_q <= HEIGHT_RESET;
			cfg_factor_q <= FACTOR_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:      cfg_width_q  <= cfg_data[WCFG_W-1:0];
				REG_IMAGE_HEIGHT:     cfg_height_q <= cfg_data[HCFG_W-1:0];
				REG_THRESHOLD_FACTOR: cfg_factor_q <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_col_q  <= '0;
			load_row_q  <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			rowsum_q    <= '0;
			res_valid_q <= 1'b0;
			bin_value_q <= BIN_LIGHT;
			col_q       <= '0;
			row_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_LOAD) begin
							rowsum_q   <= rowsum_nxt;
							load_col_q <= ld_nxt.c[COL_W-1:0];
							load_row_q <= ld_nxt.r[ROW_W-1:0];
							state_q    <= ST_LD_RD;
						end else begin
							emit_col_q <= em_nxt.c[COL_W-1:0];
							emit_row_q <= em_nxt.r[ROW_W-1:0];
							state_q    <= ST_EM_R0;
						end
					end
				end
				ST_LD_RD:  state_q <= ST_LD_WR;
				ST_LD_WR:  state_q <= ST_IDLE;
				ST_EM_R0:  state_q <= ST_EM_R1;
				ST_EM_R1:  state_q <= ST_EM_R2;
				ST_EM_R2:  state_q <= ST_EM_R3;
				ST_EM_R3:  state_q <= ST_EM_SUM;
				ST_EM_SUM: state_q <= ST_EM_MUL;
				ST_EM_MUL: state_q <= ST_EM_OUT;
				ST_EM_OUT: begin
					// Waits here until the output register is free.
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						bin_value_q <= (BOX_W'(lhs_q) < rhs_q) ? BIN_DARK : BIN_LIGHT;
						col_q       <= em_x_q;
						row_q       <= em_y_q;
						last_q      <= em_last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the beat in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_col_q  <= ld_pos.c[COL_W-1:0];
			ld_row_q  <= ld_pos.r[ROW_W-1:0];
			ld_pix_q  <= pixel;
			em_x_q    <= ex;
			em_y_q    <= ey;
			em_x1_q   <= x1;
			em_x2_q   <= x2;
			em_y1_q   <= y1;
			em_y2_q   <= y2;
			em_last_q <= is_last;
		end
		case (state_q)
			ST_EM_R0:  count_q  <= COUNT_W'(dx * dy);
			ST_EM_R1: begin
				i22_q    <= integ_rd_data;
				em_pix_q <= pix_rd_data;
			end
			ST_EM_R2:  i21_q    <= integ_rd_data;
			ST_EM_R3:  i12_q    <= integ_rd_data;
			ST_EM_SUM: begin
				// A store mixing two frames can give a negative sum; it counts as zero.
				box_q <= box_full[BOX_W] ? '0 : box_full[BOX_W-1:0];
				lhs_q <= LHS_W'(em_pix_q) * LHS_W'(count_q);
			end
			ST_EM_MUL: rhs_q <= prod[PROD_W-1:FRAC_BITS];
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign bin_value = bin_value_q;
	assign col       = col_q;
	assign row       = row_q;
	assign last      = last_q;

	// A result only ever carries one of the two output levels.
	a_bin_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (bin_value == BIN_DARK || bin_value == BIN_LIGHT))
		else $error("bin_value is neither dark nor light");

	// A load beat never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_LOAD) |=> !$rose(res_valid))
		else $error("result raised after a load beat");

	// The block holds off new beats while one is being worked on.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !pix_ready)
		else $error("beat accepted while another is in flight");

endmodule
